// ===== sv/mbk_pkg.sv =====
// Shared types, constants, and command and status structs for the k-means center engine.
package mbk_pkg;

  localparam int NUM_CENTERS = 8;
  localparam int NUM_DIMS    = 16;
  localparam int COORD_WIDTH = 32;

  localparam int CI_W    = $clog2(NUM_CENTERS);
  localparam int DI_W    = $clog2(NUM_DIMS);
  localparam int ADDR_W  = CI_W + DI_W;
  localparam int DEPTH   = NUM_CENTERS * NUM_DIMS;
  localparam int CNT_W   = 24;
  localparam int DIST_W  = 64;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int ACT_W   = 4;
  localparam int DIVC_W  = $clog2(DIFF_W + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(8);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ASSIGN = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic              capture;    // latch the accepted item
    logic              mem_rd;     // read table at addr of center ctr_ci or item center
    logic              use_ctr;    // address uses center counter, not item center
    logic [CI_W-1:0]   ctr_ci;
    logic              mem_wr_load;
    logic              mem_wr_upd;
    logic              mul_go;     // register square of diff (uses rdata)
    logic              acc_go;     // accumulate square into sum[acc_ci]
    logic [CI_W-1:0]   acc_ci;
    logic              cmp_init;
    logic              cmp_step;
    logic [CI_W-1:0]   cmp_ci;
    logic              clr_sums;
    logic              cnt_bump;
    logic              div_start;
    logic              div_step;
    logic              res_assign;
    logic              res_coord;  // read result from rdata
    logic              res_upd;
    logic              res_zero;   // read out of range
  } mbk_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       c_ok;
    logic       d_ok;
    logic       dim0;       // item carries coordinate zero
    logic       last;
    logic       div_done;
  } mbk_sts_t;

endpackage

// ===== sv/mbk_datapath.sv =====
// Datapath: center memory, distance sums, squarer, serial divider, result register.
module mbk_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mbk_pkg::mbk_cmd_t            cmd,
  output mbk_pkg::mbk_sts_t            sts,
  input  logic [1:0]                   op,
  input  logic [2:0]                   center_index,
  input  logic [3:0]                   coord_index,
  input  logic signed [31:0]           value,
  input  logic                         last_coord,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         kind,
  output logic [2:0]                   center_id,
  output logic [63:0]                  distance,
  output logic signed [31:0]           coord_value,
  output logic [23:0]                  member_count
);
  import mbk_pkg::*;

  logic [1:0]              r_op;
  logic [2:0]              r_ci;
  logic [3:0]              r_di;
  logic signed [COORD_WIDTH-1:0] r_x;
  logic                    r_last;

  logic signed [COORD_WIDTH-1:0] mem [DEPTH];
  logic signed [COORD_WIDTH-1:0] rdata;
  logic [DIST_W-1:0]       sums [NUM_CENTERS];
  logic [CNT_W-1:0]        counts [NUM_CENTERS];
  logic [DIST_W-1:0]       sq;
  logic [DIST_W-1:0]       best_d;
  logic [CI_W-1:0]         best_i;

  logic                    c_ok, d_ok;
  logic [CI_W-1:0]         ci_n;
  logic [DI_W-1:0]         di_n;
  logic [ADDR_W-1:0]       addr;

  assign c_ok = ({1'b0, r_ci} < 4'(NUM_CENTERS));
  assign d_ok = ({1'b0, r_di} < 5'(NUM_DIMS));
  assign ci_n = r_ci[CI_W-1:0];
  assign di_n = r_di[DI_W-1:0];
  assign addr = {cmd.use_ctr ? cmd.ctr_ci : ci_n, di_n};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_op   <= op;
      r_ci   <= center_index;
      r_di   <= coord_index;
      r_x    <= value[COORD_WIDTH-1:0];
      r_last <= last_coord;
    end
  end

  // divider state
  logic [DIFF_W-1:0]  dmag, quo, rem_r;
  logic               dneg;
  logic [CNT_W-1:0]   divisor;
  logic [DIVC_W-1:0]  dcnt;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W:0]    trial;
  logic [DIFF_W:0]    rem_shw;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_new;

  assign diff    = DIFF_W'(r_x) - DIFF_W'(rdata);
  assign cnt_cur = counts[ci_n];
  assign cnt_new = (cnt_cur != COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
  assign rem_shw = {rem_r, dmag[DIFF_W-1]};
  assign trial   = rem_shw - (DIFF_W+1)'(divisor);

  logic signed [DIFF_W-1:0] upd_val;
  assign upd_val = DIFF_W'(rdata) + (dneg ? -$signed(quo) : $signed(quo));

  always_ff @(posedge clk) begin
    if (cmd.mem_wr_load) mem[addr] <= r_x;
    else if (cmd.mem_wr_upd) mem[addr] <= upd_val[COORD_WIDTH-1:0];
    if (cmd.mem_rd) rdata <= mem[addr];
  end

  // squarer: one multiply, registered
  logic [DIFF_W-1:0] amag;
  assign amag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  always_ff @(posedge clk) begin
    if (cmd.mul_go) sq <= DIST_W'(amag * amag);
  end

  logic [DIST_W:0] acc_sum;
  assign acc_sum = {1'b0, sums[cmd.acc_ci]} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_sums) begin
      for (int j = 0; j < NUM_CENTERS; j++) sums[j] <= '0;
    end else if (cmd.acc_go) begin
      sums[cmd.acc_ci] <= acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_CENTERS; j++) counts[j] <= '0;
    end else if (cmd.cnt_bump) begin
      counts[ci_n] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_init) begin
      best_d <= sums[0];
      best_i <= '0;
    end else if (cmd.cmp_step && sums[cmd.cmp_ci] < best_d) begin
      best_d <= sums[cmd.cmp_ci];
      best_i <= cmd.cmp_ci;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dneg    <= diff[DIFF_W-1];
      dmag    <= amag;
      divisor <= (cnt_cur == '0) ? CNT_W'(1) : cnt_cur;
      rem_r   <= '0;
      quo     <= '0;
      dcnt    <= DIVC_W'(DIFF_W);
    end else if (cmd.div_step && dcnt != '0) begin
      dmag <= {dmag[DIFF_W-2:0], 1'b0};
      if (!trial[DIFF_W]) begin
        rem_r <= trial[DIFF_W-1:0];
        quo   <= {quo[DIFF_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_shw[DIFF_W-1:0];
        quo   <= {quo[DIFF_W-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_assign || cmd.res_coord || cmd.res_upd || cmd.res_zero) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_assign) begin
      kind         <= 1'b0;
      center_id    <= 3'(best_i);
      distance     <= best_d;
      coord_value  <= '0;
      member_count <= counts[best_i];
    end else if (cmd.res_coord || cmd.res_upd || cmd.res_zero) begin
      kind         <= 1'b1;
      center_id    <= r_ci;
      distance     <= '0;
      coord_value  <= cmd.res_zero ? 32'sd0 :
                      cmd.res_upd ? 32'(upd_val[COORD_WIDTH-1:0]) : 32'(rdata);
      member_count <= c_ok ? cnt_cur : '0;
    end
  end

  assign sts.op       = r_op;
  assign sts.c_ok     = c_ok;
  assign sts.d_ok     = d_ok;
  assign sts.dim0     = (r_di == '0);
  assign sts.last     = r_last;
  assign sts.div_done = (dcnt == '0);
endmodule

// ===== sv/mbk_ctrl.sv =====
// Controller state machine sequencing loads, assigns, updates and reads.
module mbk_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_valid,
  input  logic [3:0]           active_centers,
  input  mbk_pkg::mbk_sts_t    sts,
  output mbk_pkg::mbk_cmd_t    cmd
);
  import mbk_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_ARD   = 3'd2;  // read center j
  localparam logic [2:0] S_AMUL  = 3'd3;  // square
  localparam logic [2:0] S_AACC  = 3'd4;  // accumulate, next j
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_URD   = 3'd6;
  localparam logic [2:0] S_UDIV  = 3'd7;

  logic [2:0]      state, state_next;
  logic [CI_W:0]   j, j_next;
  logic [CI_W:0]   n_act;
  logic            ustart, ustart_next;

  always_comb begin
    if (active_centers == '0) n_act = (CI_W+1)'(1);
    else if (active_centers > 4'(NUM_CENTERS)) n_act = (CI_W+1)'(NUM_CENTERS);
    else n_act = (CI_W+1)'(active_centers);
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    j_next      = j;
    ustart_next = ustart;
    cmd.ctr_ci  = j[CI_W-1:0];
    cmd.acc_ci  = j[CI_W-1:0];
    cmd.cmp_ci  = j[CI_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        j_next = '0;
        unique case (sts.op)
          OP_LOAD: begin
            cmd.mem_wr_load = sts.c_ok && sts.d_ok;
            state_next = S_IDLE;
          end
          OP_ASSIGN: state_next = sts.d_ok ? S_ARD : S_CMP;
          OP_UPDATE: begin
            if (sts.c_ok && sts.d_ok) begin
              cmd.mem_rd   = 1'b1;
              cmd.cnt_bump = sts.dim0;
              state_next   = S_URD;
            end else begin
              state_next = S_IDLE;
            end
          end
          OP_READ: begin
            if (sts.c_ok && sts.d_ok) begin
              cmd.mem_rd = 1'b1;
              state_next = S_URD;
            end else begin
              cmd.res_zero = 1'b1;
              state_next   = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ARD: begin
        cmd.mem_rd  = 1'b1;
        cmd.use_ctr = 1'b1;
        state_next  = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_AACC;
      end
      S_AACC: begin
        cmd.acc_go = 1'b1;
        j_next     = j + 1'b1;
        state_next = (j + 1'b1 == n_act) ? S_CMP : S_ARD;
        if (j + 1'b1 == n_act) j_next = '0;
      end
      S_CMP: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (j == '0) begin
          cmd.cmp_init = 1'b1;
          j_next = (CI_W+1)'(1);
          if (n_act == (CI_W+1)'(1)) j_next = n_act;
        end else if (j < n_act) begin
          cmd.cmp_step = 1'b1;
          j_next = j + 1'b1;
        end else begin
          cmd.res_assign = 1'b1;
          cmd.clr_sums   = 1'b1;
          j_next         = '0;
          state_next     = S_IDLE;
        end
      end
      S_URD: begin
        if (sts.op == OP_READ) begin
          cmd.res_coord = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          ustart_next   = 1'b1;
          state_next    = S_UDIV;
        end
      end
      S_UDIV: begin
        ustart_next  = 1'b0;
        cmd.div_step = 1'b1;
        if (sts.div_done && !ustart) begin
          cmd.res_upd     = 1'b1;
          cmd.mem_wr_upd  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      j      <= '0;
      ustart <= 1'b0;
    end else begin
      state  <= state_next;
      j      <= j_next;
      ustart <= ustart_next;
    end
  end
endmodule

// ===== sv/minibatch_kmeans_assign_update.sv =====
// Top level of the mini-batch k-means center engine.
// One transaction at a time. An assign coordinate reads each of the N active
// centers in turn through one shared squarer and accumulates its distance, and
// the last coordinate adds a nearest-center scan; an update runs through the
// bit-serial 33-step divider.
// Input is stalled while a result waits to be taken. active_centers resets to 8.
module minibatch_kmeans_assign_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [2:0]         center_index,
  input  logic [3:0]         coord_index,
  input  logic signed [31:0] value,
  input  logic               last_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [2:0]         center_id,
  output logic [63:0]        distance,
  output logic signed [31:0] coord_value,
  output logic [23:0]        member_count
);
  import mbk_pkg::*;

  logic [ACT_W-1:0] active_centers;
  mbk_cmd_t         cmd;
  mbk_sts_t         sts;

  always_ff @(posedge clk) begin
    if (rst) active_centers <= ACT_RESET;
    else if (cfg_we) active_centers <= cfg_data;
  end

  mbk_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .active_centers, .sts, .cmd
  );

  mbk_datapath u_dp (
    .clk, .rst, .cmd, .sts, .op, .center_index, .coord_index, .value, .last_coord,
    .out_stall, .out_valid, .kind, .center_id, .distance, .coord_value, .member_count
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_kind_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> distance == '0)
    else $error("coordinate result with nonzero distance");
  a_kind_coord: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> coord_value == '0)
    else $error("assign result with nonzero coordinate");
`endif
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the mini-batch k-means center engine.
`timescale 1ns / 100ps
module tb_top;
  import mbk_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  ci;
    logic [3:0]  di;
    logic [31:0] val;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  id;
    logic [63:0] dval;
    logic [31:0] coord;
    logic [23:0] cnt;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = OP_LOAD;
  logic [2:0] center_index = 3'd0;
  logic [3:0] coord_index = 4'd0;
  logic signed [31:0] value = 32'sd0;
  logic last_coord = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [2:0] center_id;
  logic [63:0] distance;
  logic signed [31:0] coord_value;
  logic [23:0] member_count;

  minibatch_kmeans_assign_update uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .center_index(center_index), .coord_index(coord_index), .value(value),
    .last_coord(last_coord), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .center_id(center_id), .distance(distance),
    .coord_value(coord_value), .member_count(member_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] centers [NUM_CENTERS*NUM_DIMS];
  logic [63:0] dist_acc [NUM_CENTERS];
  logic [23:0] counts [NUM_CENTERS];
  logic [3:0] active_cfg;

  cmd_t pending_cmds[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  logic in_taken = 1'b0;
  int failures = 0;

  task automatic predict(input cmd_t c);
    int n;
    int best;
    logic signed [32:0] d;
    logic [63:0] mag, sq, s, bd, q;
    logic signed [63:0] nc;
    logic [23:0] cnt;
    answer_t a;
    n = (active_cfg == 0) ? 1 : (active_cfg > NUM_CENTERS ? NUM_CENTERS : active_cfg);
    a = '0;
    case (c.op)
      OP_LOAD: centers[{c.ci, c.di}] = c.val;
      OP_ASSIGN: begin
        for (int j = 0; j < n; j++) begin
          d = $signed({c.val[31], c.val}) - $signed({centers[{j[2:0], c.di}][31],
              centers[{j[2:0], c.di}]});
          mag = d < 0 ? 64'(-d) : 64'(d);
          sq = mag * mag;
          s = dist_acc[j] + sq;
          dist_acc[j] = (s < sq) ? '1 : s;
        end
        if (c.last) begin
          best = 0;
          bd = dist_acc[0];
          for (int j = 1; j < n; j++)
            if (dist_acc[j] < bd) begin
              bd = dist_acc[j];
              best = j;
            end
          for (int j = 0; j < NUM_CENTERS; j++) dist_acc[j] = '0;
          a.kind = 1'b0; a.id = best[2:0]; a.dval = bd; a.cnt = counts[best];
          expected_answers.push_back(a);
        end
      end
      OP_UPDATE: begin
        if (c.di == 0 && counts[c.ci] != COUNT_MAX) counts[c.ci]++;
        cnt = (counts[c.ci] == 0) ? 24'd1 : counts[c.ci];
        d = $signed({c.val[31], c.val}) - $signed({centers[{c.ci, c.di}][31],
            centers[{c.ci, c.di}]});
        mag = d < 0 ? 64'(-d) : 64'(d);
        q = mag / cnt;
        nc = 64'(centers[{c.ci, c.di}]) + (d < 0 ? -$signed(q) : $signed(q));
        centers[{c.ci, c.di}] = nc[31:0];
        a.kind = 1'b1; a.id = c.ci; a.coord = nc[31:0]; a.cnt = counts[c.ci];
        expected_answers.push_back(a);
      end
      default: begin
        a.kind = 1'b1; a.id = c.ci; a.coord = centers[{c.ci, c.di}];
        a.cnt = counts[c.ci];
        expected_answers.push_back(a);
      end
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          {op, center_index, coord_index, value, last_coord} = c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random idling, plus one long hold counted here
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // predictor sees accepted transactions; monitor checks results
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken)
      predict({op, center_index, coord_index, value, last_coord});
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("result with no expectation: kind %0d id %0d", kind, center_id);
        failures++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind); failures++;
        end
        if (center_id !== e.id) begin
          $error("center_id: expected %0d actual %0d", e.id, center_id); failures++;
        end
        if (distance !== e.dval) begin
          $error("distance: expected %h actual %h", e.dval, distance); failures++;
        end
        if (coord_value !== e.coord) begin
          $error("coord_value: expected %h actual %h", e.coord, coord_value);
          failures++;
        end
        if (member_count !== e.cnt) begin
          $error("member_count: expected %0d actual %0d", e.cnt, member_count);
          failures++;
        end
      end
    end
  end

  task automatic push(input logic [1:0] o, input int ci, input int di,
                      input logic [31:0] v, input logic l);
    cmd_t c;
    c.op = o; c.ci = ci[2:0]; c.di = di[3:0]; c.val = v; c.last = l;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_active(input logic [3:0] n);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= n;
    active_cfg = n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // a point with random content over the given dims, possibly extreme values
  task automatic rand_point(input int dims);
    logic [31:0] v;
    for (int d = 0; d < dims; d++) begin
      v = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 32'h7fffffff : 32'h80000000)
                                   : $urandom;
      push(OP_ASSIGN, 0, d, v, d == dims - 1);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_CENTERS; i++) begin
      dist_acc[i] = '0; counts[i] = '0;
    end
    active_cfg = ACT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // every table entry gets a value before anything reads it
    for (int c = 0; c < NUM_CENTERS; c++)
      for (int d = 0; d < NUM_DIMS; d++)
        push(OP_LOAD, c, d, (c == 0) ? 32'h80000000 : (c == 1 ? 32'h7fffffff : $urandom),
             1'b0);
    send_idle_pct = 35; recv_idle_pct = 86;
    // directed: extremes, ties, saturation, zero-count update, reads
    push(OP_ASSIGN, 0, 0, 32'h7fffffff, 1'b0);
    push(OP_ASSIGN, 0, 1, 32'h80000000, 1'b1);
    push(OP_LOAD, 2, 3, 32'h0, 1'b0);
    push(OP_LOAD, 3, 3, 32'h0, 1'b0);
    push(OP_ASSIGN, 0, 3, 32'h0, 1'b1);
    push(OP_UPDATE, 4, 5, 32'h12345678, 1'b0);
    push(OP_UPDATE, 4, 0, 32'h80000000, 1'b0);
    push(OP_UPDATE, 4, 0, 32'h7fffffff, 1'b1);
    push(OP_UPDATE, 0, 15, 32'h7fffffff, 1'b0);
    push(OP_READ, 7, 15, 32'h0, 1'b0);
    push(OP_READ, 0, 0, 32'hffffffff, 1'b1);
    push(OP_ASSIGN, 0, 15, 32'h1, 1'b1);
    drain();
    set_active(4'd1);
    rand_point(2);
    drain();
    set_active(4'd0);
    rand_point(1);
    drain();
    set_active(4'd15);
    rand_point(3);
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) push(OP_READ, $urandom_range(7), $urandom_range(15), 0, 0);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 86; recv_idle_pct = 35; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_active($urandom_range(15));
      for (int k = 0; k < 55; k++) begin
        case ($urandom_range(9))
          0, 1, 2: rand_point($urandom_range(1, 4));
          3, 4: push(OP_UPDATE, $urandom_range(7), $urandom_range(3), $urandom,
                     $urandom_range(1));
          5: push(OP_LOAD, $urandom_range(7), $urandom_range(15), $urandom,
                  $urandom_range(1));
          6, 7: push(OP_READ, $urandom_range(7), $urandom_range(15), $urandom,
                     $urandom_range(1));
          default: push(OP_ASSIGN, 0, $urandom_range(15), $urandom, 1'b1);
        endcase
      end
      drain();
    end
    set_active(4'd8);
    for (int i = 0; i < 20; i++) rand_point(2);
    drain();
    if (failures == 0)
      $display("minibatch_kmeans_assign_update test passed");
    else
      $display("minibatch_kmeans_assign_update test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("minibatch_kmeans_assign_update test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mbk_pkg.sv
sv/mbk_datapath.sv
sv/mbk_ctrl.sv
sv/minibatch_kmeans_assign_update.sv
tb/tb_top.sv
